/* hdl/rgb_yuv_color_convert_top_assert.svh */
// Assertion macros for the color converter.
`ifndef RGB_YUV_COLOR_CONVERT_TOP_ASSERT_SVH
`define RGB_YUV_COLOR_CONVERT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RYC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RYC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RYC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RYC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/ryc_pkg.sv */
// Shared types and constants of the color converter.
`timescale 1ns / 1ps
package ryc_pkg;

  typedef enum logic [1:0] {
    MODE_FWD    = 2'd0,
    MODE_CLOSED = 2'd1,
    MODE_INV    = 2'd2
  } mode_t;

  localparam int STAGES = 5;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } pix_t;

  typedef struct packed {
    logic [STAGES-1:0] adv;
  } ctrl_t;

endpackage

/* hdl/ryc_if.sv */
// Request channel interfaces: pixel in, pixel out and mode write.
`timescale 1ns / 1ps
interface ryc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_first;
  logic [7:0] in_second;
  logic [7:0] in_third;
  modport source (output valid, in_first, in_second, in_third, input ready);
  modport sink (input valid, in_first, in_second, in_third, output ready);
endinterface

interface ryc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;
  modport source (output valid, out_first, out_second, out_third, input ready);
  modport sink (input valid, out_first, out_second, out_third, output ready);
endinterface

interface ryc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] conversion_mode;
  modport source (output valid, conversion_mode, input ready);
  modport sink (input valid, conversion_mode, output ready);
endinterface

/* hdl/ryc_datapath.sv */
// Five-stage fixed-point datapath of the BT.709 converter.
`timescale 1ns / 1ps
module ryc_datapath #(
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic          clk,
  input  ryc_pkg::ctrl_t ctrl,
  input  logic [1:0]    mode,
  input  ryc_pkg::pix_t pix_i,
  output ryc_pkg::pix_t pix_o
);

  localparam int F  = COEFF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = CW + 9;
  localparam int AW = F + 12;

  localparam logic signed [CW-1:0] ONE  = CW'(64'd1 << F);
  localparam logic signed [CW-1:0] K_YR = CW'(((64'd212600 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_YG = CW'(((64'd715200 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_YB = CW'(((64'd72200 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_UR = CW'(((64'd114572 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_UG = CW'(((64'd385428 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_HF = CW'(((64'd500000 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_VG = CW'(((64'd454153 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_VB = CW'(((64'd45847 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_RV = CW'(((64'd1574800 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_GU = CW'(((64'd187330 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_GV = CW'(((64'd468130 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_BU = CW'(((64'd1855630 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] R_U  = CW'(((64'd10000 << F) + 64'd9278) / 64'd18556);
  localparam logic signed [CW-1:0] R_V  = CW'(((64'd10000 << F) + 64'd7874) / 64'd15748);
  localparam logic signed [AW-1:0] OFFS = AW'(64'd128 << F);
  localparam logic [AW:0]          HALF = (AW+1)'(64'd1 << (F - 1));

  function automatic logic [7:0] round_clamp(input logic signed [AW-1:0] acc);
    logic [AW:0]   s;
    logic [AW-F:0] q;
    s = (AW+1)'(unsigned'(acc)) + HALF;
    q = s[AW:F];
    if (acc < 0) begin
      round_clamp = 8'd0;
    end else if (q > (AW-F+1)'(255)) begin
      round_clamp = 8'd255;
    end else begin
      round_clamp = q[7:0];
    end
  endfunction

  // stage 1: coefficient/operand selection and products
  logic signed [CW-1:0] coef [3][3];
  logic signed [8:0]    opnd [3][3];
  logic signed [8:0]    op_a, op_b, op_c, op_u, op_v;
  logic                 inv;

  always_comb begin
    inv  = (mode == ryc_pkg::MODE_INV);
    op_a = 9'({1'b0, pix_i.first});
    op_b = 9'({1'b0, pix_i.second});
    op_c = 9'({1'b0, pix_i.third});
    op_u = op_b - 9'sd128;
    op_v = op_c - 9'sd128;
    if (inv) begin
      coef[0][0] = ONE;   opnd[0][0] = op_a;
      coef[0][1] = K_RV;  opnd[0][1] = op_v;
      coef[0][2] = '0;    opnd[0][2] = '0;
      coef[1][0] = ONE;   opnd[1][0] = op_a;
      coef[1][1] = -K_GU; opnd[1][1] = op_u;
      coef[1][2] = -K_GV; opnd[1][2] = op_v;
      coef[2][0] = ONE;   opnd[2][0] = op_a;
      coef[2][1] = K_BU;  opnd[2][1] = op_u;
      coef[2][2] = '0;    opnd[2][2] = '0;
    end else begin
      coef[0][0] = K_YR;  opnd[0][0] = op_a;
      coef[0][1] = K_YG;  opnd[0][1] = op_b;
      coef[0][2] = K_YB;  opnd[0][2] = op_c;
      coef[1][0] = -K_UR; opnd[1][0] = op_a;
      coef[1][1] = -K_UG; opnd[1][1] = op_b;
      coef[1][2] = K_HF;  opnd[1][2] = op_c;
      coef[2][0] = K_HF;  opnd[2][0] = op_a;
      coef[2][1] = -K_VG; opnd[2][1] = op_b;
      coef[2][2] = -K_VB; opnd[2][2] = op_c;
    end
  end

  logic signed [PW-1:0] prod1 [3][3];
  logic [1:0]           mode1;
  logic [7:0]           a1, c1;

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[i][j] <= coef[i][j] * opnd[i][j];
        end
      end
      mode1 <= mode;
      a1    <= pix_i.first;
      c1    <= pix_i.third;
    end
  end

  // stage 2: accumulate
  logic signed [AW-1:0] acc2 [3];
  logic [1:0]           mode2;
  logic [7:0]           a2, c2;
  logic signed [AW-1:0] off2;

  always_comb begin
    off2 = (mode1 == ryc_pkg::MODE_INV) ? '0 : OFFS;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      acc2[0] <= AW'(prod1[0][0]) + AW'(prod1[0][1]) + AW'(prod1[0][2]);
      acc2[1] <= AW'(prod1[1][0]) + AW'(prod1[1][1]) + AW'(prod1[1][2]) + off2;
      acc2[2] <= AW'(prod1[2][0]) + AW'(prod1[2][1]) + AW'(prod1[2][2]) + off2;
      mode2   <= mode1;
      a2      <= a1;
      c2      <= c1;
    end
  end

  // stage 3: round and clamp
  logic [7:0] r3 [3];
  logic [1:0] mode3;
  logic [7:0] a3, c3;

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        r3[i] <= round_clamp(acc2[i]);
      end
      mode3 <= mode2;
      a3    <= a2;
      c3    <= c2;
    end
  end

  // stage 4: closed-loop chroma products from rounded Y
  logic signed [8:0]    du, dv;
  logic signed [PW-1:0] pu4, pv4;
  logic [7:0]           r4 [3];
  logic [1:0]           mode4;

  always_comb begin
    du = 9'({1'b0, c3}) - 9'({1'b0, r3[0]});
    dv = 9'({1'b0, a3}) - 9'({1'b0, r3[0]});
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      pu4   <= R_U * du;
      pv4   <= R_V * dv;
      r4    <= r3;
      mode4 <= mode3;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      pix_o.first <= r4[0];
      if (mode4 == ryc_pkg::MODE_CLOSED) begin
        pix_o.second <= round_clamp(AW'(pu4) + OFFS);
        pix_o.third  <= round_clamp(AW'(pv4) + OFFS);
      end else begin
        pix_o.second <= r4[1];
        pix_o.third  <= r4[2];
      end
    end
  end

endmodule

/* hdl/rgb_yuv_color_convert_top.sv */
// Top level of the full-range BT.709 RGB/YCbCr converter.
`timescale 1ns / 1ps
// Usage:
//   pix_in  : one 8-bit three-component color per request (valid/ready).
//   pix_out : one converted color per input request, in order.
//   cfg     : writes conversion_mode (0 forward matrix, 1 forward
//             closed-loop, 2 inverse, 3 same as 0). Always ready; write
//             only while no request is in flight.
// Throughput: one request per cycle unless pix_out stalls; five register
//   stages (products, accumulate, round/clamp, closed-loop products,
//   output) each hold one request, so a new color enters every cycle.
// Stall: each stage advances when empty or when the stage after it
//   advances; with pix_out stalled, bubbles still fill, then pix_in.ready
//   drops. Nothing is lost or repeated.
// Reset: rst (synchronous) empties the pipeline and sets the mode to
//   forward matrix.
`include "rgb_yuv_color_convert_top_assert.svh"
module rgb_yuv_color_convert_top #(
  parameter int COEFF_FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  ryc_in_if.sink   pix_in,
  ryc_out_if.source pix_out,
  ryc_cfg_if.sink  cfg
);

  localparam int N = ryc_pkg::STAGES;

  logic [1:0]     mode;
  logic [N-1:0]   vld;
  ryc_pkg::ctrl_t ctrl;
  ryc_pkg::pix_t  pix_i;
  ryc_pkg::pix_t  pix_o;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ryc_pkg::MODE_FWD;
    end else if (cfg.valid) begin
      mode <= cfg.conversion_mode;
    end
  end

  always_comb begin
    ctrl.adv[N-1] = !vld[N-1] || pix_out.ready;
    for (int k = N - 2; k >= 0; k--) begin
      ctrl.adv[k] = !vld[k] || ctrl.adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctrl.adv[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (ctrl.adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pix_in.ready = ctrl.adv[0];
  assign pix_i.first  = pix_in.in_first;
  assign pix_i.second = pix_in.in_second;
  assign pix_i.third  = pix_in.in_third;

  ryc_datapath #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_dp (
    .clk  (clk),
    .ctrl (ctrl),
    .mode (mode),
    .pix_i(pix_i),
    .pix_o(pix_o)
  );

  assign pix_out.valid      = vld[N-1];
  assign pix_out.out_first  = pix_o.first;
  assign pix_out.out_second = pix_o.second;
  assign pix_out.out_third  = pix_o.third;

  `RYC_ASSERT_NOW(a_empty_out_ready, clk, rst, !pix_out.valid, pix_in.ready)
  `RYC_ASSERT_NXT(a_accept_enters, clk, rst, pix_in.valid && pix_in.ready, vld[0])
  `RYC_ASSERT_NXT(a_held_stays, clk, rst, vld[N-1] && !pix_out.ready, vld[N-1])
  `RYC_ASSERT_NXT(a_mid_held, clk, rst, vld[2] && !ctrl.adv[2], vld[2])

endmodule
